@@ design/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_NXT_ALWAYS(name, clk, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/wsqm_pkg.sv @@
// ---------------------------------------------------------------------------
// wsqm_pkg
// Shared types and constants of the weighted sliding quantile margin block.
// ---------------------------------------------------------------------------
package wsqm_pkg;

  localparam int CFG_W      = 24;  // widest configuration register
  localparam int CFG_ADDR_W = 3;
  localparam int MARGIN_W   = 24;
  localparam int FRAC_W     = 17;  // Q1.16 fields
  localparam int CNT_W      = 32;
  localparam int WIN_W      = 6;

  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'd65536;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_INITIAL_MARGIN  = 3'd0,
    REG_MIN_MARGIN      = 3'd1,
    REG_MAX_MARGIN      = 3'd2,
    REG_DECAY_FACTOR    = 3'd3,
    REG_TARGET_COVERAGE = 3'd4,
    REG_WINDOW_IN_USE   = 3'd5
  } cfg_reg_t;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Phase strobes broadcast to every cell.
  typedef struct packed {
    logic shift;    // new error enters cell 0, others move up one age
    logic wgt;      // weight chain update
    logic p_load;   // load the probe ring, clear accumulators
    logic p_run;    // rotate the probe ring, accumulate
    logic s_load;   // load the scan chain
    logic s_run;    // shift the scan chain toward cell 0
  } cell_ctrl_t;

endpackage

@@ design/wsqm_if.sv @@
// ---------------------------------------------------------------------------
// wsqm_if
// Valid/ready channels carrying the input word and the result word.
// ---------------------------------------------------------------------------
interface wsqm_in_if #(parameter int ERR_W = 24);
  logic             valid;
  logic             ready;
  logic             operation;
  logic [ERR_W-1:0] error_value;

  modport source (output valid, operation, error_value, input ready);
  modport sink   (input valid, operation, error_value, output ready);
endinterface

interface wsqm_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] margin;
  logic [16:0] coverage;
  logic        was_covered;

  modport source (output valid, margin, coverage, was_covered, input ready);
  modport sink   (input valid, margin, coverage, was_covered, output ready);
endinterface

@@ design/weighted_sliding_quantile_margin.sv @@
// Weighted sliding quantile margin. An add word runs through these steps
// from acceptance to result: the age-weight chain steps at acceptance and
// then through the S_WGT state, one pass rotates every stored error past
// every cell to build cumulative weights, the S_MUL state scales the total,
// one pass shifts the cells out to pick the smallest qualifying error, then
// a 16-step divider forms the coverage ratio (or gives 1.0 directly when
// every observation so far was covered). A clear word goes from acceptance
// straight to the output stage.
// One word is worked on at a time; a finished result sits in the output
// register while the next word is accepted and processed. A result that
// cannot leave because the output register is still full holds the block.
// ---------------------------------------------------------------------------
// weighted_sliding_quantile_margin
// Sliding-window weighted quantile over prediction errors, with coverage.
// ---------------------------------------------------------------------------
module weighted_sliding_quantile_margin import wsqm_pkg::*; #(
  parameter int WINDOW_DEPTH = 32,
  parameter int ERROR_WIDTH  = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  wsqm_in_if.sink               sample,
  wsqm_out_if.source            result,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int D   = WINDOW_DEPTH;
  localparam int EW  = ERROR_WIDTH;
  localparam int FW  = $clog2(D + 1);
  localparam int AW  = FRAC_W + FW;
  localparam int CW  = (D > 1) ? $clog2(D) : 1;
  localparam int MW  = (EW > MARGIN_W) ? EW : MARGIN_W;
  localparam int WXW = (FW > WIN_W) ? FW : WIN_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WGT   = 7'b0000010,
    S_PROBE = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state;

  logic [MARGIN_W-1:0] init_margin, clamp_lo, clamp_hi;
  logic [FRAC_W-1:0]   decay_factor, target_cov;
  logic [WIN_W-1:0]    win_in_use;

  logic [FW-1:0]       fill;
  logic [CNT_W-1:0]    obs_count, hit_count;
  logic [MARGIN_W-1:0] margin_reg, margin_now;
  logic [CW-1:0]       cnt;
  logic                cnt_last;
  logic                covered;
  logic [AW-1:0]       total;
  logic [FRAC_W+AW-1:0] cov_total;
  logic [EW-1:0]       best;
  logic                found;
  logic [FRAC_W-1:0]   cov_res;

  logic [FRAC_W-1:0]   decay_eff, cov_eff;
  logic [WXW-1:0]      win_x;
  logic [FW-1:0]       win_eff, fill_inc;
  logic [EW-1:0]       err_in;
  logic                accept;
  logic                head_ok;
  logic [MW-1:0]       best_x, clamped;
  logic                div_start, div_done;
  logic [FRAC_W-1:0]   div_q;
  cell_ctrl_t          ctrl;

  logic [EW-1:0]       c_val [D];
  logic [FRAC_W-1:0]   c_wt  [D];
  logic [EW-1:0]       c_pv  [D];
  logic [FRAC_W-1:0]   c_pw  [D];
  logic                c_pvl [D];
  logic [AW-1:0]       c_acc [D];

  assign accept     = sample.valid && sample.ready;
  assign sample.ready = (state == S_IDLE);
  assign err_in     = EW'(sample.error_value);
  assign margin_now = (fill == '0) ? init_margin : margin_reg;
  assign cnt_last   = (cnt == CW'(D - 1));

  assign decay_eff = (decay_factor > ONE_Q16) ? ONE_Q16 : decay_factor;
  assign cov_eff   = (target_cov > ONE_Q16) ? ONE_Q16 : target_cov;
  assign win_x     = WXW'(win_in_use);
  always_comb begin
    if (win_x == '0)            win_eff = FW'(1);
    else if (win_x > WXW'(D))   win_eff = FW'(D);
    else                        win_eff = FW'(win_x);
  end
  assign fill_inc = (fill >= win_eff) ? win_eff : fill + FW'(1);

  assign ctrl.shift  = accept && (sample.operation == OP_ADD);
  // the weight chain settles through every cell before the probe ring loads
  assign ctrl.wgt    = ctrl.shift || (state == S_WGT);
  assign ctrl.p_load = (state == S_WGT) && cnt_last;
  assign ctrl.p_run  = (state == S_PROBE);
  assign ctrl.s_load = (state == S_MUL);
  assign ctrl.s_run  = (state == S_SCAN);
  assign div_start   = (state == S_SCAN) && cnt_last;

  // cell 0 is the head of the scan chain
  assign head_ok = c_pvl[0] &&
                   ({1'b0, c_acc[0], 16'b0} >= cov_total) &&
                   (!found || c_pv[0] < best);

  assign best_x = MW'(best);
  always_comb begin
    if (best_x < MW'(clamp_lo))      clamped = MW'(clamp_lo);
    else if (best_x > MW'(clamp_hi)) clamped = MW'(clamp_hi);
    else                             clamped = best_x;
  end

  genvar k;
  generate
    for (k = 0; k < D; k++) begin : g_cell
      wsqm_cell #(.EW(EW), .FW(FW), .AW(AW), .IDX(k)) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .fill     (fill),
        .decay    (decay_eff),
        .prev_val ((k == 0) ? err_in : c_val[(k + D - 1) % D]),
        .prev_wt  (c_wt[(k + D - 1) % D]),
        .prev_pv  (c_pv[(k + D - 1) % D]),
        .prev_pw  (c_pw[(k + D - 1) % D]),
        .next_pv  (c_pv[(k + 1) % D]),
        .next_pvl ((k == D - 1) ? 1'b0 : c_pvl[(k + 1) % D]),
        .next_acc ((k == D - 1) ? '0 : c_acc[(k + 1) % D]),
        .val      (c_val[k]),
        .wt       (c_wt[k]),
        .pv       (c_pv[k]),
        .pw       (c_pw[k]),
        .pvl      (c_pvl[k]),
        .acc      (c_acc[k])
      );
    end
  endgenerate

  wsqm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .hit   (hit_count),
    .obs   (obs_count),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      init_margin  <= 24'd19661;
      clamp_lo     <= 24'd3277;
      clamp_hi     <= 24'd65536;
      decay_factor <= 17'd62259;
      target_cov   <= 17'd58982;
      win_in_use   <= 6'd32;
      fill         <= '0;
      obs_count    <= '0;
      hit_count    <= '0;
      result.valid <= 1'b0;
      cnt          <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_INITIAL_MARGIN:  init_margin  <= cfg_wdata;
          REG_MIN_MARGIN:      clamp_lo     <= cfg_wdata;
          REG_MAX_MARGIN:      clamp_hi     <= cfg_wdata;
          REG_DECAY_FACTOR:    decay_factor <= cfg_wdata[FRAC_W-1:0];
          REG_TARGET_COVERAGE: target_cov   <= cfg_wdata[FRAC_W-1:0];
          REG_WINDOW_IN_USE:   win_in_use   <= cfg_wdata[WIN_W-1:0];
          default: ;
        endcase
      end

      // S_FIN reloads the output register itself
      if (result.valid && result.ready && (state != S_FIN)) result.valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (sample.operation == OP_CLEAR) begin
              fill      <= '0;
              obs_count <= '0;
              hit_count <= '0;
              covered   <= 1'b0;
              cov_res   <= ONE_Q16;
              state     <= S_FIN;
            end else begin
              covered <= MW'(err_in) <= MW'(margin_now);
              if (obs_count != '1) obs_count <= obs_count + 1'b1;
              if ((MW'(err_in) <= MW'(margin_now)) && (hit_count != '1)) begin
                hit_count <= hit_count + 1'b1;
              end
              fill  <= fill_inc;
              cnt   <= '0;
              state <= S_WGT;
            end
          end
        end
        S_WGT: begin
          cnt <= cnt_last ? '0 : cnt + 1'b1;
          total <= '0;
          if (cnt_last) state <= S_PROBE;
        end
        S_PROBE: begin
          total <= total + AW'(c_pw[0]);
          cnt   <= cnt_last ? '0 : cnt + 1'b1;
          if (cnt_last) state <= S_MUL;
        end
        S_MUL: begin
          cov_total <= cov_eff * total;
          found     <= 1'b0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          if (head_ok) begin
            best  <= c_pv[0];
            found <= 1'b1;
          end
          cnt <= cnt_last ? '0 : cnt + 1'b1;
          if (cnt_last) state <= S_DIV;
        end
        S_DIV: begin
          margin_reg <= clamped[MARGIN_W-1:0];
          if (div_done) begin
            cov_res <= div_q;
            state   <= S_FIN;
          end
        end
        S_FIN: begin
          if (!result.valid || result.ready) begin
            result.valid       <= 1'b1;
            result.margin      <= margin_now;
            result.coverage    <= cov_res;
            result.was_covered <= covered;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/wsqm_cell.sv @@
// ---------------------------------------------------------------------------
// wsqm_cell
// One window slot: stored error, its age weight, its cumulative weight and
// the probe/scan registers passed to the neighbors.
// ---------------------------------------------------------------------------
module wsqm_cell import wsqm_pkg::*; #(
  parameter int EW  = 24,
  parameter int FW  = 6,
  parameter int AW  = 23,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [FW-1:0]     fill,
  input  logic [FRAC_W-1:0] decay,
  input  logic [EW-1:0]     prev_val,
  input  logic [FRAC_W-1:0] prev_wt,
  input  logic [EW-1:0]     prev_pv,
  input  logic [FRAC_W-1:0] prev_pw,
  input  logic [EW-1:0]     next_pv,
  input  logic              next_pvl,
  input  logic [AW-1:0]     next_acc,
  output logic [EW-1:0]     val,
  output logic [FRAC_W-1:0] wt,
  output logic [EW-1:0]     pv,
  output logic [FRAC_W-1:0] pw,
  output logic              pvl,
  output logic [AW-1:0]     acc
);

  logic                    valid;
  logic [2*FRAC_W-1:0]     prod;

  assign valid = FW'(IDX) < fill;
  assign prod  = prev_wt * decay;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      val <= prev_val;
    end
    if (ctrl.wgt) begin
      // weight is at most 1.0 since decay is clamped
      wt <= (IDX == 0) ? ONE_Q16 : prod[16 +: FRAC_W];
    end
    if (ctrl.p_load) begin
      pv  <= val;
      pw  <= valid ? wt : '0;
      acc <= '0;
    end else if (ctrl.p_run) begin
      if (pv <= val) acc <= acc + AW'(pw);
      pv <= prev_pv;
      pw <= prev_pw;
    end else if (ctrl.s_load) begin
      pv  <= val;
      pvl <= valid;
    end else if (ctrl.s_run) begin
      pv  <= next_pv;
      pvl <= next_pvl;
      acc <= next_acc;
    end
  end

endmodule

@@ design/wsqm_div.sv @@
// ---------------------------------------------------------------------------
// wsqm_div
// Radix-2 restoring divider: hit * 65536 / obs, hit <= obs, one bit a cycle.
// ---------------------------------------------------------------------------
module wsqm_div import wsqm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CNT_W-1:0]  hit,
  input  logic [CNT_W-1:0]  obs,
  output logic              done,
  output logic [FRAC_W-1:0] quo
);

  logic [CNT_W:0]   rem;
  logic [CNT_W:0]   rem2;
  logic             ge;
  logic [3:0]       cnt;
  logic             running;

  assign rem2 = {rem[CNT_W-1:0], 1'b0};
  assign ge   = rem2 >= {1'b0, obs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (hit == obs) begin
          // full coverage, also the no-observation case
          quo  <= ONE_Q16;
          done <= 1'b1;
        end else begin
          rem     <= {1'b0, hit};
          quo     <= '0;
          cnt     <= '0;
          running <= 1'b1;
        end
      end else if (running) begin
        rem <= ge ? rem2 - {1'b0, obs} : rem2;
        quo <= {quo[FRAC_W-2:0], ge};
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/wsqm_checker.sv @@
// ---------------------------------------------------------------------------
// wsqm_checker
// Port-level checks on the weighted sliding quantile margin block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wsqm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_coverage
);

  `ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result word dropped")
  `ASSERT_IMP(a_cov_range, clk, rst, out_valid, out_coverage <= 17'd65536, "coverage above one")
  `ASSERT_NXT(a_add_busy, clk, rst, in_valid && in_ready && !in_op, !in_ready, "add word not busy")
  `ASSERT_NXT_ALWAYS(a_rst_empty, clk, rst, !out_valid, "result valid after reset")

endmodule

bind weighted_sliding_quantile_margin wsqm_checker u_wsqm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample.valid),
  .in_ready     (sample.ready),
  .in_op        (sample.operation),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_coverage (result.coverage)
);

@@ tb/weighted_sliding_quantile_margin_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// weighted_sliding_quantile_margin_tb
// Drives add/clear words through several register settings and checks each
// result word against a window-quantile predictor or a fixed expected word.
// ---------------------------------------------------------------------------
module weighted_sliding_quantile_margin_tb;
  import wsqm_pkg::*;

  localparam int DEPTH       = 32;
  localparam int SETTLE      = 3 * DEPTH + 40;  // a bit past one add word
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_LEN    = 2000;

  typedef struct {
    logic        op;
    logic [23:0] err;
    bit          typed;
    logic [23:0] margin;
    logic [16:0] coverage;
    logic        was_covered;
  } stim_row_t;

  typedef struct {
    logic [23:0] margin;
    logic [16:0] coverage;
    logic        was_covered;
  } margin_word_t;

  typedef struct {
    logic [23:0] init_m;
    logic [23:0] min_m;
    logic [23:0] max_m;
    logic [16:0] decay;
    logic [16:0] level;
    logic [5:0]  win;
    int          words;
  } setting_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  wsqm_in_if #(.ERR_W(24)) sample_ch ();
  wsqm_out_if              result_ch ();

  weighted_sliding_quantile_margin #(.WINDOW_DEPTH(DEPTH), .ERROR_WIDTH(24)) dut (
    .clk(clk), .rst(rst), .sample(sample_ch), .result(result_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [23:0] win_err [DEPTH];
  int unsigned fill_q, slot_q;
  logic [23:0] margin_q;
  logic [31:0] obs_q, hits_q;
  logic [23:0] r_init = 24'd19661, r_min = 24'd3277, r_max = 24'd65536;
  logic [16:0] r_decay = 17'd62259, r_level = 17'd58982;
  logic [5:0]  r_win = 6'd32;

  margin_word_t expected_q [$];
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  squeeze = 0;

  function automatic logic [23:0] window_quantile();
    logic [23:0] val [DEPTH];
    longint unsigned wt [DEPTH];
    longint unsigned total, w, sum, d, lvl;
    logic [23:0] best, largest;
    bit found;
    int n;
    n = fill_q;
    if (n == 0) return r_init;
    d   = (r_decay > ONE_Q16) ? 65536 : r_decay;
    lvl = (r_level > ONE_Q16) ? 65536 : r_level;
    total = 0; w = 65536; largest = '0; best = '0; found = 0;
    for (int a = 0; a < n; a++) begin
      val[a] = win_err[(slot_q + DEPTH - 1 - a) % DEPTH];
      wt[a] = w;
      total += w;
      w = (w * d) >> 16;
      if (val[a] > largest) largest = val[a];
    end
    for (int i = 0; i < n; i++) begin
      sum = 0;
      for (int j = 0; j < n; j++)
        if (val[j] <= val[i]) sum += wt[j];
      if (sum * 65536 >= lvl * total) begin
        if (!found || val[i] < best) best = val[i];
        found = 1;
      end
    end
    if (!found) best = largest;
    if (best < r_min) best = r_min;
    else if (best > r_max) best = r_max;
    return best;
  endfunction

  function automatic margin_word_t predict_word(logic op, logic [23:0] e);
    margin_word_t r;
    int unsigned weff;
    r.was_covered = 1'b0;
    if (op == OP_CLEAR) begin
      fill_q = 0; slot_q = 0; obs_q = '0; hits_q = '0;
      margin_q = r_init;
    end else begin
      if (obs_q != 32'hFFFF_FFFF) obs_q++;
      if (e <= margin_q) begin
        r.was_covered = 1'b1;
        if (hits_q != 32'hFFFF_FFFF) hits_q++;
      end
      win_err[slot_q] = e;
      slot_q = (slot_q + 1) % DEPTH;
      weff = (r_win < 1) ? 1 : (r_win > DEPTH) ? DEPTH : r_win;
      fill_q = (fill_q + 1 > weff) ? weff : fill_q + 1;
      margin_q = window_quantile();
    end
    r.margin = margin_q;
    r.coverage = (obs_q == 0) ? ONE_Q16
               : 17'((longint'(hits_q) * 65536) / longint'(obs_q));
    return r;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [23:0] v);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_INITIAL_MARGIN: begin
        r_init = v;
        if (fill_q == 0) margin_q = v;
      end
      REG_MIN_MARGIN:      r_min = v;
      REG_MAX_MARGIN:      r_max = v;
      REG_DECAY_FACTOR:    r_decay = v[16:0];
      REG_TARGET_COVERAGE: r_level = v[16:0];
      REG_WINDOW_IN_USE:   r_win = v[5:0];
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // offers one word, holds it until taken, queues its expectation
  task automatic send_word(logic op, logic [23:0] e, bit typed, margin_word_t fixed);
    int gap;
    bit took;
    margin_word_t p;
    gap = pick_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.operation   <= op;
    sample_ch.error_value <= e;
    do begin
      @(negedge clk);
      took = sample_ch.ready;
      @(posedge clk);
    end while (!took);
    p = predict_word(op, e);
    expected_q.insert(expected_q.size(), typed ? fixed : p);
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [23:0] random_error();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 24'($urandom_range(0, 20'h1FFFF));
    if (p < 70) return 24'(margin_q + $urandom_range(0, 8192) - 4096);
    if (p < 95) return 24'($urandom);
    return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h0;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (squeeze && !hold_done) begin
      hold_done = 1;
      hold_left = HOLD_LEN;
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) result_ch.ready <= 1'b1;
      else if (p < 97) result_ch.ready <= 1'b0;
      else begin
        hold_left = $urandom_range(20, 120);
        result_ch.ready <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word");
        fail_count++;
      end else begin
        margin_word_t x;
        x = expected_q[0];
        expected_q.delete(0);
        if (result_ch.margin !== x.margin) begin
          $error("margin: expected %0d, got %0d", x.margin, result_ch.margin);
          fail_count++;
        end
        if (result_ch.coverage !== x.coverage) begin
          $error("coverage: expected %0d, got %0d", x.coverage, result_ch.coverage);
          fail_count++;
        end
        if (result_ch.was_covered !== x.was_covered) begin
          $error("was_covered: expected %0d, got %0d", x.was_covered,
                 result_ch.was_covered);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  stim_row_t directed [] = '{
    '{OP_CLEAR, 24'h0,      1, 24'd19661, 17'd65536, 1'b0},
    '{OP_ADD,   24'h0,      1, 24'd3277,  17'd65536, 1'b1},
    '{OP_ADD,   24'hFFFFFF, 1, 24'd65536, 17'd32768, 1'b0},
    '{OP_ADD,   24'd65536,  0, '0, '0, 1'b0},  // exactly on the margin
    '{OP_ADD,   24'd65537,  0, '0, '0, 1'b0},
    '{OP_ADD,   24'd1,      0, '0, '0, 1'b0},
    '{OP_ADD,   24'h800000, 0, '0, '0, 1'b0},
    '{OP_ADD,   24'h7FFFFF, 0, '0, '0, 1'b0},
    '{OP_ADD,   24'd3277,   0, '0, '0, 1'b0},
    '{OP_ADD,   24'd3276,   0, '0, '0, 1'b0},
    '{OP_CLEAR, 24'hFFFFFF, 1, 24'd19661, 17'd65536, 1'b0},  // data ignored
    '{OP_CLEAR, 24'h0,      1, 24'd19661, 17'd65536, 1'b0},
    '{OP_ADD,   24'd19661,  0, '0, '0, 1'b0},
    '{OP_ADD,   24'd19662,  0, '0, '0, 1'b0},
    '{OP_ADD,   24'hAAAAAA, 0, '0, '0, 1'b0},
    '{OP_ADD,   24'h555555, 0, '0, '0, 1'b0}
  };

  // min above max is a crossed clamp; window 0 and 63 are out of range;
  // decay and level above one saturate
  setting_t settings [] = '{
    '{24'd19661,  24'd3277,  24'd65536,  17'd62259,  17'd58982, 6'd32, 110},
    '{24'd0,      24'd0,     24'hFFFFFF, 17'd65536,  17'd32768, 6'd1,  80},
    '{24'hFFFFFF, 24'd0,     24'hFFFFFF, 17'd0,      17'd65536, 6'd0,  80},
    '{24'd40000,  24'd100,   24'd200000, 17'h1FFFF,  17'd0,     6'd63, 110},
    '{24'd20000,  24'd90000, 24'd10000,  17'd50000,  17'd45000, 6'd8,  90},
    '{24'd30000,  24'd0,     24'hFFFFFF, 17'd65535,  17'h1FFFF, 6'd32, 110},
    '{24'd12345,  24'd50,    24'd131072, 17'd32768,  17'd65535, 6'd5,  100},
    '{24'd65536,  24'd1000,  24'd90000,  17'd1,      17'd1,     6'd31, 90},
    '{24'd500,    24'hFFFFFF,24'hFFFFFF, 17'd60000,  17'd52000, 6'd2,  90},
    '{24'd19661,  24'd3277,  24'd65536,  17'd64000,  17'd58982, 6'd32, 200}
  };

  initial begin
    margin_word_t dummy;
    margin_word_t fixed;
    fill_q = 0; slot_q = 0; obs_q = '0; hits_q = '0; margin_q = r_init;
    dummy = '{'0, '0, 1'b0};
    sample_ch.valid = 1'b0;
    sample_ch.operation = OP_ADD;
    sample_ch.error_value = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      fixed = '{directed[i].margin, directed[i].coverage, directed[i].was_covered};
      send_word(directed[i].op, directed[i].err, directed[i].typed, fixed);
    end
    drain();

    foreach (settings[k]) begin
      write_reg(REG_MIN_MARGIN, settings[k].min_m);
      write_reg(REG_MAX_MARGIN, settings[k].max_m);
      write_reg(REG_DECAY_FACTOR, 24'(settings[k].decay));
      write_reg(REG_TARGET_COVERAGE, 24'(settings[k].level));
      write_reg(REG_WINDOW_IN_USE, 24'(settings[k].win));
      write_reg(REG_INITIAL_MARGIN, settings[k].init_m);
      if (k == 1) squeeze = 1;
      for (int n = 0; n < settings[k].words; n++) begin
        if ($urandom_range(0, 99) < 3)
          send_word(OP_CLEAR, 24'($urandom), 0, dummy);
        else
          send_word(OP_ADD, random_error(), 0, dummy);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/wsqm_pkg.sv
design/wsqm_if.sv
design/wsqm_cell.sv
design/wsqm_div.sv
design/weighted_sliding_quantile_margin.sv
design/wsqm_checker.sv
tb/weighted_sliding_quantile_margin_tb.sv
